>>> design/mbx_pkg.sv
// ----------------------------------------------------------------------------
// mbx_pkg
// Shared constants, request codes and the command type for the mailbox unit.
// ----------------------------------------------------------------------------
package mbx_pkg;

    localparam int DEF_CORE_COUNT    = 4;
    localparam int DEF_MBOX_PER_CORE = 4;

    localparam int SEL_W         = 2;
    localparam int SEL_RANGE     = 1 << SEL_W;
    localparam int DATA_W        = 32;
    localparam int LINE_W        = 4;
    localparam int MASK_W        = 16;
    localparam int MASK_POS_W    = $clog2(MASK_W);
    localparam int PEND_BASE_BIT = 4;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 40;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;

    localparam int CFG_ADDR_W = 1;
    localparam logic [CFG_ADDR_W-1:0] CFG_FIQ_MASK = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_IRQ_MASK = 1'b1;

    localparam logic [SEL_W-1:0] REQ_SET   = 2'd0;
    localparam logic [SEL_W-1:0] REQ_CLEAR = 2'd1;
    localparam logic [SEL_W-1:0] REQ_READ  = 2'd2;
    localparam logic [SEL_W-1:0] REQ_PEND  = 2'd3;

    typedef struct packed {
        logic [SEL_W-1:0]  op;
        logic              hit;
        logic [SEL_W-1:0]  core;
        logic [SEL_W-1:0]  mbox;
        logic [DATA_W-1:0] data;
    } mbx_cmd_t;

    localparam int CMD_W = $bits(mbx_cmd_t);

    // Enable bit at position pos; positions past the mask count as disabled.
    function automatic logic routed(input logic [MASK_W-1:0] mask, input int pos);
        logic bit_on;
        bit_on = 1'b0;
        if (pos < MASK_W) begin
            bit_on = mask[pos[MASK_POS_W-1:0]];
        end
        return bit_on;
    endfunction

endpackage

>>> design/mbx_front.sv
// ----------------------------------------------------------------------------
// mbx_front
// Accepts bus transactions, unpacks the fields and range-checks the access.
// ----------------------------------------------------------------------------
module mbx_front
    import mbx_pkg::*;
#(
    parameter int CORE_COUNT    = DEF_CORE_COUNT,
    parameter int MBOX_PER_CORE = DEF_MBOX_PER_CORE
) (
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_TDATA_W-1:0] s_tdata,
    input  logic                  q_full,
    output logic                  q_push,
    output mbx_cmd_t              q_cmd
);

    logic core_ok;
    logic mbox_ok;

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    always_comb begin
        q_cmd.op   = s_tdata[1:0];
        q_cmd.core = s_tdata[3:2];
        q_cmd.mbox = s_tdata[5:4];
        q_cmd.data = s_tdata[37:6];
        core_ok    = int'(q_cmd.core) < CORE_COUNT;
        mbox_ok    = int'(q_cmd.mbox) < MBOX_PER_CORE;
        // pending reads ignore the mailbox field
        q_cmd.hit  = core_ok && (mbox_ok || (q_cmd.op == REQ_PEND));
    end

endmodule

>>> design/mbx_queue.sv
// ----------------------------------------------------------------------------
// mbx_queue
// Two-entry command queue between the front and back ends.
// ----------------------------------------------------------------------------
module mbx_queue
    import mbx_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [CMD_W-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic             valid,
    output logic [CMD_W-1:0] dout
);

    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    logic [CMD_W-1:0]   mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;

    assign full  = count_reg == CNT_W'(Q_DEPTH);
    assign valid = count_reg != '0;
    assign dout  = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> valid)
        else $error("queue pop while empty");

    a_count_up: assert property (@(posedge aclk) disable iff (!aresetn)
        push && !pop |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not advance on push");

endmodule

>>> design/mbx_back.sv
// ----------------------------------------------------------------------------
// mbx_back
// Mailbox store, enable masks, interrupt line routing and the result register.
// ----------------------------------------------------------------------------
module mbx_back
    import mbx_pkg::*;
#(
    parameter int CORE_COUNT    = DEF_CORE_COUNT,
    parameter int MBOX_PER_CORE = DEF_MBOX_PER_CORE
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   q_valid,
    input  mbx_cmd_t               q_cmd,
    output logic                   q_pop,
    input  logic                   cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [MASK_W-1:0]      cfg_wdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    // select fields are two bits wide, so only this many cores/mailboxes exist
    localparam int CORES_USED = (CORE_COUNT < SEL_RANGE) ? CORE_COUNT : SEL_RANGE;
    localparam int MBOX_USED  = (MBOX_PER_CORE < SEL_RANGE) ? MBOX_PER_CORE : SEL_RANGE;
    localparam int ENTRIES    = CORES_USED * MBOX_USED;
    localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    logic [DATA_W-1:0]  words_reg [ENTRIES];
    logic [ENTRIES-1:0] nz_reg;
    logic [ENTRIES-1:0] nz_next;
    logic [MASK_W-1:0]  fiq_mask_reg;
    logic [MASK_W-1:0]  irq_mask_reg;
    logic               m_tvalid_reg;
    logic [DATA_W-1:0]  rdata_reg;
    logic [LINE_W-1:0]  fiq_reg;
    logic [LINE_W-1:0]  irq_reg;

    logic [IDX_W-1:0]   idx;
    logic [DATA_W-1:0]  cur_word;
    logic [DATA_W-1:0]  word_next;
    logic               wr_en;
    logic [DATA_W-1:0]  rdata_next;
    logic [LINE_W-1:0]  fiq_next;
    logic [LINE_W-1:0]  irq_next;

    assign q_pop    = q_valid && (!m_tvalid_reg || m_tready);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {irq_reg, fiq_reg, rdata_reg};

    always_comb begin
        idx        = IDX_W'(int'(q_cmd.core) * MBOX_USED + int'(q_cmd.mbox));
        cur_word   = words_reg[idx];
        word_next  = cur_word;
        wr_en      = 1'b0;
        rdata_next = '0;
        nz_next    = nz_reg;
        fiq_next   = '0;
        irq_next   = '0;
        if (q_pop && q_cmd.hit) begin
            case (q_cmd.op)
                REQ_SET: begin
                    word_next = cur_word | q_cmd.data;
                    wr_en     = 1'b1;
                end
                REQ_CLEAR: begin
                    word_next = cur_word & ~q_cmd.data;
                    wr_en     = 1'b1;
                end
                REQ_READ: begin
                    rdata_next = cur_word;
                end
                REQ_PEND: begin
                    for (int m = 0; m < MBOX_USED; m++) begin
                        if (nz_reg[IDX_W'(int'(q_cmd.core) * MBOX_USED + m)] &&
                            routed(fiq_mask_reg, int'(q_cmd.core) * MBOX_PER_CORE + m)) begin
                            rdata_next[PEND_BASE_BIT + m] = 1'b1;
                        end
                    end
                end
                default: begin
                    rdata_next = '0;
                end
            endcase
        end
        if (wr_en) begin
            nz_next[idx] = |word_next;
        end
        for (int c = 0; c < CORES_USED; c++) begin
            for (int m = 0; m < MBOX_USED; m++) begin
                if (nz_next[IDX_W'(c * MBOX_USED + m)]) begin
                    if (routed(fiq_mask_reg, c * MBOX_PER_CORE + m)) begin
                        fiq_next[c] = 1'b1;
                    end
                    if (routed(irq_mask_reg, c * MBOX_PER_CORE + m)) begin
                        irq_next[c] = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
            fiq_mask_reg <= '0;
            irq_mask_reg <= '0;
            nz_reg       <= '0;
            for (int i = 0; i < ENTRIES; i++) begin
                words_reg[i] <= '0;
            end
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_FIQ_MASK: fiq_mask_reg <= cfg_wdata;
                    CFG_IRQ_MASK: irq_mask_reg <= cfg_wdata;
                    default: begin
                        fiq_mask_reg <= fiq_mask_reg;
                    end
                endcase
            end
            if (q_pop) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (wr_en) begin
                words_reg[idx] <= word_next;
            end
            nz_reg <= nz_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            rdata_reg <= rdata_next;
            fiq_reg   <= fiq_next;
            irq_reg   <= irq_next;
        end
    end

    a_pop_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |=> m_tvalid_reg)
        else $error("result register not loaded after pop");

    a_lines_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> ((fiq_reg >> CORES_USED) == '0) && ((irq_reg >> CORES_USED) == '0))
        else $error("request line raised for a missing core");

    a_fiq_needs_mask: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && (|fiq_reg) |-> (|fiq_mask_reg))
        else $error("FIQ line raised with FIQ mask clear");

endmodule

>>> design/interprocessor_mailbox_unit_core.sv
// ----------------------------------------------------------------------------
// interprocessor_mailbox_unit_core
// Inter-core mailboxes with set/clear/read/pending access and FIQ/IRQ line routing.
//
//   channel  dir  width  contents (low bit first)
//   s_       in   40     req_type[1:0], target_core[3:2], mailbox_index[5:4],
//                        write_data[37:6], zero pad
//   m_       out  40     read_data[31:0], fiq_lines[35:32], irq_lines[39:36]
//   cfg_     in   16     index 0 fiq_enable_mask, index 1 irq_enable_mask
//
// One transaction per cycle sustained while m_tready stays high; m_tvalid rises after
// the request passes the queue write, then the store update into the result register.
// Reset clears the mailbox store and both masks in the reset cycle.
// A single-cycle m_tready stall fills the two-entry queue and drops s_tready
// for one cycle.
// ----------------------------------------------------------------------------
module interprocessor_mailbox_unit_core
    import mbx_pkg::*;
#(
    parameter int CORE_COUNT    = DEF_CORE_COUNT,
    parameter int MBOX_PER_CORE = DEF_MBOX_PER_CORE
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // req_type, target_core, mailbox_index, write_data
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // read_data, fiq_lines, irq_lines
    output logic [OUT_TDATA_W-1:0] m_tdata,
    input  logic                   cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [MASK_W-1:0]      cfg_wdata
);

    mbx_cmd_t         front_cmd;
    mbx_cmd_t         back_cmd;
    logic             q_push;
    logic             q_full;
    logic             q_pop;
    logic             q_valid;
    logic [CMD_W-1:0] q_dout;

    assign back_cmd = mbx_cmd_t'(q_dout);

    mbx_front #(
        .CORE_COUNT    (CORE_COUNT),
        .MBOX_PER_CORE (MBOX_PER_CORE)
    ) u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (front_cmd)
    );

    mbx_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .din     (front_cmd),
        .full    (q_full),
        .pop     (q_pop),
        .valid   (q_valid),
        .dout    (q_dout)
    );

    mbx_back #(
        .CORE_COUNT    (CORE_COUNT),
        .MBOX_PER_CORE (MBOX_PER_CORE)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_cmd     (back_cmd),
        .q_pop     (q_pop),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

>>> dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for interprocessor_mailbox_unit_core. A directed table
// runs set/clear/read/pending accesses and mask writes, then randomized
// phases of mailbox exchanges plus noise under several mask settings. Every
// result transaction is checked field by field against an in-bench mailbox
// model (or a typed row's own expectation), with random idling on both streams and one long output hold-off.
// ----------------------------------------------------------------------------
module tb;
    import mbx_pkg::*;

    localparam int CORES           = DEF_CORE_COUNT;
    localparam int MBOXES          = DEF_MBOX_PER_CORE;
    localparam int ITEMS_PER_PHASE = 220;
    localparam int RX_HOLD_CYCLES  = 300;
    localparam int IDLE_SETTLE     = 4;
    localparam int WATCHDOG_LIMIT  = 2000;

    typedef struct packed {
        logic [LINE_W-1:0] irq;
        logic [LINE_W-1:0] fiq;
        logic [DATA_W-1:0] rd;
    } mbox_reply_t;

    typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_e;

    typedef struct {
        row_kind_e             kind;
        logic [SEL_W-1:0]      req;
        logic [SEL_W-1:0]      core;
        logic [SEL_W-1:0]      mbox;
        logic [DATA_W-1:0]     data;
        logic [CFG_ADDR_W-1:0] reg_idx;
        bit                    typed;
        mbox_reply_t           reply;
    } dir_row_t;

    typedef struct {
        logic [MASK_W-1:0] fiq;
        logic [MASK_W-1:0] irq;
        bit                gaps;
        bit                stalls;
        bit                hold;
    } phase_cfg_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_wr_en;
    logic [CFG_ADDR_W-1:0]  cfg_addr;
    logic [MASK_W-1:0]      cfg_wdata;

    // typed expectation travels alongside the request
    bit          s_typed;
    mbox_reply_t s_typed_reply;

    logic [DATA_W-1:0] mbox_word [CORES*MBOXES];
    logic [MASK_W-1:0] fiq_en;
    logic [MASK_W-1:0] irq_en;
    mbox_reply_t       mbox_reply_q[$];

    int unsigned error_count;
    int unsigned reply_count;
    int unsigned stall_cycles;
    bit          tx_gaps_on;
    bit          rx_stalls_on;
    bit          rx_hold_req;

    dir_row_t   dir_tab[$];
    phase_cfg_t phase_tab[$];

    interprocessor_mailbox_unit_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // ---------------- mailbox model ----------------
    function automatic logic [LINE_W-1:0] core_lines(input logic [MASK_W-1:0] mask);
        logic [LINE_W-1:0] l;
        l = '0;
        for (int c = 0; c < CORES && c < LINE_W; c++) begin
            for (int m = 0; m < MBOXES; m++) begin
                if (mbox_word[c*MBOXES+m] != '0 && mask[c*MBOXES+m])
                    l[c] = 1'b1;
            end
        end
        return l;
    endfunction

    function automatic mbox_reply_t predict_access(input logic [SEL_W-1:0] req,
                                                   input logic [SEL_W-1:0] core,
                                                   input logic [SEL_W-1:0] mbox,
                                                   input logic [DATA_W-1:0] data);
        mbox_reply_t r;
        int          idx;
        r   = '0;
        idx = int'(core) * MBOXES + int'(mbox);
        case (req)
            REQ_SET:   mbox_word[idx] = mbox_word[idx] | data;
            REQ_CLEAR: mbox_word[idx] = mbox_word[idx] & ~data;
            REQ_READ:  r.rd = mbox_word[idx];
            REQ_PEND: begin
                for (int m = 0; m < MBOXES; m++) begin
                    if (mbox_word[int'(core)*MBOXES+m] != '0 && fiq_en[int'(core)*MBOXES+m])
                        r.rd[PEND_BASE_BIT+m] = 1'b1;
                end
            end
            default: ;
        endcase
        r.fiq = core_lines(fiq_en);
        r.irq = core_lines(irq_en);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got_v,
                                   input logic [DATA_W-1:0] exp_v);
        $display("mismatch #%0d %s: got %h expected %h", reply_count, what, got_v, exp_v);
        error_count++;
    endtask

    // ---------------- monitor / scoreboard ----------------
    always @(posedge aclk) begin : mon
        mbox_reply_t pred;
        mbox_reply_t got;
        mbox_reply_t want;
        if (!aresetn) begin
            foreach (mbox_word[i]) mbox_word[i] = '0;
            fiq_en = '0;
            irq_en = '0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_FIQ_MASK: fiq_en = cfg_wdata;
                    CFG_IRQ_MASK: irq_en = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                pred = predict_access(s_tdata[1:0], s_tdata[3:2], s_tdata[5:4],
                                      s_tdata[37:6]);
                if (s_typed)
                    pred = s_typed_reply;
                mbox_reply_q.push_back(pred);
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                reply_count++;
                if (mbox_reply_q.size() == 0) begin
                    report_mismatch("unexpected transaction", got.rd, '0);
                end else begin
                    want = mbox_reply_q.pop_front();
                    if (got.rd !== want.rd)
                        report_mismatch("read_data", got.rd, want.rd);
                    if (got.fiq !== want.fiq)
                        report_mismatch("fiq_lines", 32'(got.fiq), 32'(want.fiq));
                    if (got.irq !== want.irq)
                        report_mismatch("irq_lines", 32'(got.irq), 32'(want.irq));
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", stall_cycles);
            $display("** interprocessor_mailbox_unit_core: FAILED **");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // ---------------- result sink ----------------
    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (rx_hold_req) begin
                m_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge aclk);
                m_tready <= 1'b1;
                rx_hold_req = 1'b0;
            end else if (rx_stalls_on && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // ---------------- stimulus ----------------
    task automatic send_access(input logic [SEL_W-1:0] req, input logic [SEL_W-1:0] core,
                               input logic [SEL_W-1:0] mbox, input logic [DATA_W-1:0] data,
                               input bit typed, input mbox_reply_t typed_reply);
        if (tx_gaps_on && $urandom_range(0, 6) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
        s_tvalid      <= 1'b1;
        s_tdata       <= {2'b00, data, mbox, core, req};
        s_typed       <= typed;
        s_typed_reply <= typed_reply;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (mbox_reply_q.size() != 0) @(posedge aclk);
        repeat (IDLE_SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [MASK_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
    endtask

    function automatic logic [DATA_W-1:0] rand_word();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2, 3:    return 32'h1 << $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    function automatic dir_row_t item_row(input logic [SEL_W-1:0] req,
                                          input logic [SEL_W-1:0] core,
                                          input logic [SEL_W-1:0] mbox,
                                          input logic [DATA_W-1:0] data, input bit typed,
                                          input logic [DATA_W-1:0] rd,
                                          input logic [LINE_W-1:0] fiq,
                                          input logic [LINE_W-1:0] irq);
        dir_row_t r;
        r.kind      = ROW_ITEM;
        r.req       = req;
        r.core      = core;
        r.mbox      = mbox;
        r.data      = data;
        r.reg_idx   = CFG_FIQ_MASK;
        r.typed     = typed;
        r.reply.rd  = rd;
        r.reply.fiq = fiq;
        r.reply.irq = irq;
        return r;
    endfunction

    function automatic dir_row_t cfg_row(input logic [CFG_ADDR_W-1:0] idx,
                                         input logic [MASK_W-1:0] val);
        dir_row_t r;
        r         = item_row(REQ_READ, '0, '0, 32'(val), 1'b0, '0, '0, '0);
        r.kind    = ROW_CFG;
        r.reg_idx = idx;
        return r;
    endfunction

    initial begin
        logic [SEL_W-1:0]  req;
        logic [SEL_W-1:0]  core;
        logic [SEL_W-1:0]  mbox;
        logic [DATA_W-1:0] data;
        int                n;

        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_typed       = 1'b0;
        s_typed_reply = '0;
        cfg_wr_en     = 1'b0;
        cfg_addr      = CFG_FIQ_MASK;
        cfg_wdata     = '0;
        tx_gaps_on    = 1'b0;
        rx_stalls_on  = 1'b0;
        rx_hold_req   = 1'b0;
        error_count   = 0;
        reply_count   = 0;

        // directed table
        dir_tab.push_back(item_row(REQ_READ,  2'd0, 2'd0, 32'h0,        1, 32'h0,        0, 0));
        dir_tab.push_back(item_row(REQ_PEND,  2'd3, 2'd0, 32'hffffffff, 1, 32'h0,        0, 0));
        dir_tab.push_back(item_row(REQ_SET,   2'd0, 2'd0, 32'hffffffff, 1, 32'h0,        0, 0));
        dir_tab.push_back(item_row(REQ_READ,  2'd0, 2'd0, 32'h0,        1, 32'hffffffff, 0, 0));
        dir_tab.push_back(cfg_row(CFG_FIQ_MASK, 16'hffff));
        dir_tab.push_back(cfg_row(CFG_IRQ_MASK, 16'hffff));
        dir_tab.push_back(item_row(REQ_PEND,  2'd0, 2'd3, 32'h0,        1, 32'h10,       1, 1));
        dir_tab.push_back(item_row(REQ_CLEAR, 2'd0, 2'd0, 32'h0000ffff, 1, 32'h0,        1, 1));
        dir_tab.push_back(item_row(REQ_READ,  2'd0, 2'd0, 32'h0,        1, 32'hffff0000, 1, 1));
        // bit raised after the read must survive the clear of what was read
        dir_tab.push_back(item_row(REQ_SET,   2'd0, 2'd0, 32'h00000001, 0, 0, 0, 0));
        dir_tab.push_back(item_row(REQ_CLEAR, 2'd0, 2'd0, 32'hffff0000, 0, 0, 0, 0));
        dir_tab.push_back(item_row(REQ_READ,  2'd0, 2'd0, 32'h0,        0, 0, 0, 0));
        dir_tab.push_back(item_row(REQ_CLEAR, 2'd0, 2'd0, 32'hffffffff, 1, 32'h0,        0, 0));
        dir_tab.push_back(item_row(REQ_SET,   2'd3, 2'd3, 32'h80000000, 1, 32'h0,        8, 8));
        dir_tab.push_back(item_row(REQ_SET,   2'd1, 2'd2, 32'ha5a5a5a5, 0, 0, 0, 0));
        dir_tab.push_back(item_row(REQ_SET,   2'd2, 2'd1, 32'h5a5a5a5a, 0, 0, 0, 0));
        dir_tab.push_back(item_row(REQ_PEND,  2'd3, 2'd0, 32'h0,        0, 0, 0, 0));
        dir_tab.push_back(item_row(REQ_PEND,  2'd1, 2'd1, 32'hffffffff, 0, 0, 0, 0));
        dir_tab.push_back(item_row(REQ_READ,  2'd3, 2'd3, 32'hffffffff, 0, 0, 0, 0));
        dir_tab.push_back(cfg_row(CFG_FIQ_MASK, 16'h0000));
        dir_tab.push_back(item_row(REQ_PEND,  2'd3, 2'd2, 32'h0,        0, 0, 0, 0));
        dir_tab.push_back(cfg_row(CFG_IRQ_MASK, 16'h8421));
        dir_tab.push_back(item_row(REQ_CLEAR, 2'd1, 2'd2, 32'h0,        0, 0, 0, 0));
        dir_tab.push_back(item_row(REQ_READ,  2'd2, 2'd1, 32'h0,        0, 0, 0, 0));

        phase_tab.push_back('{16'hffff, 16'hffff, 1, 0, 0});
        phase_tab.push_back('{16'($urandom), 16'($urandom), 0, 1, 0});
        phase_tab.push_back('{16'hffff, 16'h0000, 0, 0, 1});
        phase_tab.push_back('{16'h0000, 16'hffff, 1, 1, 0});
        phase_tab.push_back('{16'($urandom), 16'($urandom), 1, 1, 0});
        phase_tab.push_back('{16'($urandom), 16'($urandom), 0, 0, 0});

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_tab[i]) begin
            if (dir_tab[i].kind == ROW_CFG) begin
                wait_idle();
                write_reg(dir_tab[i].reg_idx, dir_tab[i].data[MASK_W-1:0]);
                cfg_wr_en <= 1'b0;
            end else begin
                send_access(dir_tab[i].req, dir_tab[i].core, dir_tab[i].mbox, dir_tab[i].data,
                            dir_tab[i].typed, dir_tab[i].reply);
            end
        end

        foreach (phase_tab[p]) begin
            tx_gaps_on   = 1'b0;
            rx_stalls_on = 1'b0;
            wait_idle();
            write_reg(CFG_FIQ_MASK, phase_tab[p].fiq);
            write_reg(CFG_IRQ_MASK, phase_tab[p].irq);
            cfg_wr_en    <= 1'b0;
            tx_gaps_on   = phase_tab[p].gaps;
            rx_stalls_on = phase_tab[p].stalls;
            if (phase_tab[p].hold)
                rx_hold_req = 1'b1;
            n = 0;
            while (n < ITEMS_PER_PHASE) begin
                core = SEL_W'($urandom_range(0, 3));
                mbox = SEL_W'($urandom_range(0, 3));
                if ($urandom_range(0, 9) < 6) begin
                    // sender posts, owner polls pending, reads the word, acks it
                    data = rand_word();
                    send_access(REQ_SET, core, mbox, data, 1'b0, '0);
                    send_access(REQ_PEND, core, 2'($urandom), $urandom, 1'b0, '0);
                    send_access(REQ_READ, core, mbox, $urandom, 1'b0, '0);
                    if ($urandom_range(0, 3) == 0)
                        data = '1;
                    send_access(REQ_CLEAR, core, mbox, data, 1'b0, '0);
                    n += 4;
                end else begin
                    case ($urandom_range(0, 3))
                        0:       req = REQ_SET;
                        1:       req = REQ_CLEAR;
                        2:       req = REQ_READ;
                        default: req = REQ_PEND;
                    endcase
                    data = (req == REQ_CLEAR && $urandom_range(0, 9) < 4) ? '1 : rand_word();
                    send_access(req, core, mbox, data, 1'b0, '0);
                    n++;
                end
            end
        end

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (mbox_reply_q.size() != 0) @(posedge aclk);
        repeat (IDLE_SETTLE) @(posedge aclk);

        if (error_count == 0) begin
            $display("** interprocessor_mailbox_unit_core: PASSED **");
        end else begin
            $display("** interprocessor_mailbox_unit_core: FAILED **");
        end
        $finish;
    end

endmodule
